@@ src/heap_allocation_map_engine_defines.svh @@
// assertion helpers for the checker of the heap map engine
`ifndef HEAP_ALLOCATION_MAP_ENGINE_DEFINES_SVH
`define HEAP_ALLOCATION_MAP_ENGINE_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define HAMAP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define HAMAP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

@@ src/hamap_pkg.sv @@
package hamap_pkg;

	localparam int ADDR_W    = 16;
	localparam int LEN_W     = 11;
	localparam int OWN_W     = 4;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		CMD_MARK     = 2'd0,
		CMD_FREE     = 2'd1,
		CMD_FREE_ALL = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OUTSIDE   = 2'd1,
		ST_NOT_OWNER = 2'd2,
		ST_EXCEEDS   = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_SIZE  = 1'b1;

	localparam logic [OWN_W-1:0] NIB_FREE = 4'h0;
	localparam logic [OWN_W-1:0] NIB_CONT = 4'hF;

	localparam logic [LEN_W-1:0] USE_SIZE_RST = 11'd1024;

	typedef struct packed {
		cmd_t             cmd;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  length;
		logic [OWN_W-1:0]  owner;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] chunk_start;
		logic [LEN_W-1:0]  chunk_size;
		logic [OWN_W-1:0]  chunk_owner;
	} rsp_t;

	// one command as handed to the sequencer, area already resolved
	typedef struct packed {
		cmd_t              cmd;
		logic              in_area;
		logic [LEN_W-1:0]  off;
		logic [LEN_W-1:0]  n;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  length;
		logic [OWN_W-1:0]  owner;
	} job_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

@@ src/hamap_ram.sv @@
module hamap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/hamap_seq.sv @@
module hamap_seq import hamap_pkg::*; #(
	parameter int MAP_BYTES = 512,
	localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  job_t              job,
	input  logic              res_take,
	output seq_stat_t         stat,
	output rsp_t              res,
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output logic [BYTE_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]  mem_raddr,
	input  logic [BYTE_W-1:0] mem_rdata
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_START = 9'b000000100,
		S_BACK  = 9'b000001000,
		S_ZBACK = 9'b000010000,
		S_FWD   = 9'b000100000,
		S_MARK  = 9'b001000000,
		S_ALL   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  clr_q, clr_d;
	logic              rd_q;
	job_t              job_q, job_d;
	logic [LEN_W-1:0]  cur_q, cur_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  h_q, h_d;
	logic              flag_q, flag_d;
	status_t           st_q, st_d;
	logic [ADDR_W-1:0] cs_q, cs_d;
	logic [OWN_W-1:0]  own_q, own_d;

	logic              phase;
	logic              step_back;
	logic [LEN_W-1:0]  cur_step;
	logic [LEN_W-1:0]  cnt_inc;
	logic [LEN_W-1:0]  len_e;
	logic              end_past;
	logic [OWN_W-1:0]  v;
	logic [OWN_W-1:0]  wnib;
	logic              free_now;
	logic              all_hit;

	function automatic status_t own_chk(input cmd_t cmd, input logic [OWN_W-1:0] own,
			input logic [OWN_W-1:0] who);
		return (cmd == CMD_FREE && own != who) ? ST_NOT_OWNER : ST_OK;
	endfunction

	assign phase = (state_q == S_BACK) || (state_q == S_ZBACK) || (state_q == S_FWD) ||
		(state_q == S_MARK) || (state_q == S_ALL);
	assign step_back = (state_q == S_BACK) || (state_q == S_ZBACK);

	// the one cursor stepper, forwards or backwards over nibble offsets
	assign cur_step = cur_q + (step_back ? {LEN_W{1'b1}} : LEN_W'(1));
	assign cnt_inc  = cnt_q + LEN_W'(1);

	assign len_e    = (job_q.length == '0) ? LEN_W'(1) : job_q.length;
	assign end_past = ({1'b0, job_q.off} + {1'b0, len_e}) > {1'b0, job_q.n};

	// even offset in the high nibble
	assign v = cur_q[0] ? mem_rdata[3:0] : mem_rdata[7:4];

	assign free_now = (job_q.cmd == CMD_FREE) && (own_q == job_q.owner);
	assign all_hit  = (flag_q && v == NIB_CONT) ||
		(v == job_q.owner && job_q.owner != NIB_FREE &&
		(job_q.owner != NIB_CONT || cur_q == '0));

	assign mem_raddr = IDX_W'(cur_q >> 1);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : mem_raddr;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 :
		(cur_q[0] ? {mem_rdata[7:4], wnib} : {wnib, mem_rdata[3:0]});

	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		job_d   = job_q;
		cur_d   = cur_q;
		cnt_d   = cnt_q;
		h_d     = h_q;
		flag_d  = flag_q;
		st_d    = st_q;
		cs_d    = cs_q;
		own_d   = own_q;
		mem_we  = 1'b0;
		wnib    = NIB_FREE;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + IDX_W'(1);
				if (clr_q == IDX_W'(MAP_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					job_d   = job;
					state_d = S_START;
				end
			end
			S_START: begin
				cnt_d  = '0;
				st_d   = ST_OK;
				cs_d   = '0;
				own_d  = NIB_FREE;
				flag_d = 1'b1;
				if (job_q.cmd == CMD_FREE_ALL) begin
					cs_d    = job_q.base;
					own_d   = job_q.owner;
					cur_d   = '0;
					flag_d  = 1'b0;
					state_d = (job_q.n == '0) ? S_DONE : S_ALL;
				end else if (!job_q.in_area) begin
					st_d    = ST_OUTSIDE;
					state_d = S_DONE;
				end else if (job_q.cmd == CMD_MARK) begin
					if (job_q.owner == NIB_FREE || job_q.owner == NIB_CONT) begin
						st_d    = ST_NOT_OWNER;
						state_d = S_DONE;
					end else if (end_past) begin
						st_d    = ST_EXCEEDS;
						state_d = S_DONE;
					end else begin
						cs_d    = job_q.addr;
						own_d   = job_q.owner;
						cur_d   = job_q.off;
						state_d = S_MARK;
					end
				end else begin
					cur_d   = job_q.off;
					state_d = S_BACK;
				end
			end
			S_BACK: begin
				if (rd_q) begin
					flag_d = 1'b0;
					if (flag_q && v == NIB_FREE) begin
						// free byte: walk back over the free run
						h_d = cur_q;
						if (cur_q == '0) begin
							cs_d    = job_q.base + ADDR_W'(cur_q);
							own_d   = NIB_FREE;
							st_d    = own_chk(job_q.cmd, NIB_FREE, job_q.owner);
							state_d = S_DONE;
						end else begin
							cur_d   = cur_step;
							state_d = S_ZBACK;
						end
					end else if (v == NIB_CONT && cur_q != '0) begin
						cur_d = cur_step;
					end else begin
						cs_d    = job_q.base + ADDR_W'(cur_q);
						own_d   = v;
						st_d    = own_chk(job_q.cmd, v, job_q.owner);
						state_d = (v == NIB_FREE) ? S_DONE : S_FWD;
					end
				end
			end
			S_ZBACK: begin
				if (rd_q) begin
					if (v == NIB_FREE && cur_q != '0) begin
						h_d   = cur_q;
						cur_d = cur_step;
					end else begin
						cs_d    = job_q.base + ADDR_W'((v == NIB_FREE) ? cur_q : h_q);
						own_d   = NIB_FREE;
						st_d    = own_chk(job_q.cmd, NIB_FREE, job_q.owner);
						state_d = S_DONE;
					end
				end
			end
			S_FWD: begin
				if (rd_q) begin
					if (cnt_q == '0 || v == NIB_CONT) begin
						cnt_d  = cnt_inc;
						mem_we = free_now;
						if (cur_step == job_q.n) begin
							state_d = S_DONE;
						end else begin
							cur_d = cur_step;
						end
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_MARK: begin
				if (rd_q) begin
					mem_we = 1'b1;
					wnib   = (cnt_q == '0) ? job_q.owner : NIB_CONT;
					cnt_d  = cnt_inc;
					if (cnt_inc == len_e) begin
						state_d = S_DONE;
					end else begin
						cur_d = cur_step;
					end
				end
			end
			S_ALL: begin
				if (rd_q) begin
					// flag marks an open chunk whose continuation bytes go too
					flag_d = all_hit;
					if (all_hit) begin
						mem_we = 1'b1;
						cnt_d  = cnt_inc;
					end
					if (cur_step == job_q.n) begin
						state_d = S_DONE;
					end else begin
						cur_d = cur_step;
					end
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			// rd_q alternates: issue the read, then use the registered byte
			rd_q    <= phase && !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		job_q  <= job_d;
		cur_q  <= cur_d;
		cnt_q  <= cnt_d;
		h_q    <= h_d;
		flag_q <= flag_d;
		st_q   <= st_d;
		cs_q   <= cs_d;
		own_q  <= own_d;
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);

	assign res.status      = st_q;
	assign res.chunk_start = cs_q;
	assign res.chunk_size  = cnt_q;
	assign res.chunk_owner = own_q;

endmodule

@@ src/heap_allocation_map_engine.sv @@
// Nibble heap allocation map: one 4-bit entry per usable heap byte, two per map byte.
// Requests arrive on req (valid/ready), one beat per command; every command gives
// exactly one beat on rsp (valid/ready). The config port (cfg_we, cfg_idx,
// cfg_wdata) sets use_start and use_size; the user must write it only while the
// block idles, as the block itself does not enforce this. Commands are handled one
// at a time by a sequencer that steps a single cursor over the map, reading the
// byte of each nibble visited and then using it (read-modify-write when it writes),
// since the map RAM has one registered read port and one write port.
// Nibbles visited per command: none for an outside address or a refused mark;
// len for a mark; for query/free the walk back to the chunk head and the walk
// forward over the chunk up to one nibble past its end; the whole area for free
// all (area length up to 2*MAP_BYTES).
// req_ready rises with response valid when the output register is free.
// A new request is taken as soon as the result has moved to the output register,
// so a stalled receiver holds one finished result while the next command runs;
// a second finished result waits in the sequencer and blocks further requests.
// After reset the map is cleared, one byte per cycle, with req_ready low; the
// config registers take use_start 0 and use_size 1024 at once.
module heap_allocation_map_engine import hamap_pkg::*; #(
	parameter int MAP_BYTES = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	localparam int IDX_W   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int MAX_NIB = 2 * MAP_BYTES;

	logic [ADDR_W-1:0] use_start_q;
	logic [LEN_W-1:0]  use_size_q;
	logic              ov_q;
	rsp_t              rsp_q;

	logic [ADDR_W:0]   lim;
	logic [LEN_W-1:0]  area_n;
	logic [ADDR_W-1:0] off;
	job_t              job;
	seq_stat_t         stat;
	rsp_t              res;
	logic              take;
	logic              start;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_start_q <= '0;
			use_size_q  <= USE_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_USE_START: use_start_q <= cfg_wdata;
				CFG_USE_SIZE:  use_size_q  <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// area length: use_size, capped by the map and by the top of address space
	always_comb begin
		lim    = {1'b1, {ADDR_W{1'b0}}} - {1'b0, use_start_q};
		area_n = use_size_q;
		if (32'(use_size_q) > MAX_NIB) begin
			area_n = LEN_W'(MAX_NIB);
		end
		if ((ADDR_W + 1)'(area_n) > lim) begin
			area_n = lim[LEN_W-1:0];
		end
	end

	assign off = req.addr - use_start_q;

	always_comb begin
		job.cmd     = req.cmd;
		job.in_area = (req.addr >= use_start_q) && (off < ADDR_W'(area_n));
		job.off     = off[LEN_W-1:0];
		job.n       = area_n;
		job.addr    = req.addr;
		job.base    = use_start_q;
		job.length  = req.length;
		job.owner   = req.owner;
	end

	assign req_ready = stat.idle;
	assign start     = req_valid && req_ready;
	assign take      = !ov_q || rsp_ready;

	hamap_seq #(
		.MAP_BYTES(MAP_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.job      (job),
		.res_take (take),
		.stat     (stat),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	hamap_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAP_BYTES)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register parts the sequencer from a stalled receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (stat.done && take) begin
			ov_q <= 1'b1;
		end else if (rsp_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = ov_q;
	assign rsp       = rsp_q;

endmodule

@@ src/hamap_chk.sv @@
`include "heap_allocation_map_engine_defines.svh"

module hamap_chk import hamap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled result beat holds
	`HAMAP_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp beat changed while stalled")

	// one command at a time: ready drops after each request beat
	`HAMAP_ASSERT(a_one_cmd, clk, arst_n, req_valid && req_ready |=> !req_ready, "request taken while busy")

	// a result only appears after the sequencer has been busy
	`HAMAP_ASSERT(a_rsp_after_work, clk, arst_n, $rose(rsp_valid) |-> $past(!req_ready), "result without work")

	// refused by area checks: chunk fields are zero
	`HAMAP_NEVER(a_refused_zero, clk, arst_n, rsp_valid && (rsp.status == ST_OUTSIDE || rsp.status == ST_EXCEEDS) && (rsp.chunk_start != '0 || rsp.chunk_size != '0 || rsp.chunk_owner != '0), "area refusal with chunk data")

endmodule

bind heap_allocation_map_engine hamap_chk u_chk (.*);
